@@ hw/rtl/wwog_pkg.sv @@
// shared widths, codes and types of the weld weave offset generator
`timescale 1ns / 1ps

package wwog_pkg;

	localparam int POS_W      = 32;
	localparam int VEC_W      = 16;
	localparam int ARC_W      = 32;
	localparam int MODE_W     = 3;
	localparam int AMP_W      = 25;
	localparam int FREQ_W     = 24;
	localparam int FREQ100_W  = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 25;
	localparam int PHASE_FRAC = 40;
	localparam int SIN_W      = 15;
	localparam int SIN_FRAC   = 14;
	localparam int OFF_W      = AMP_W + 1;
	localparam int LAT_W      = 2 * VEC_W + 1;
	localparam int LAT_SHIFT  = 28;
	localparam int LM_W       = 30;
	localparam int NM_W       = 28;
	localparam int SUM_W      = POS_W + 2;

	localparam logic [MODE_W-1:0] MODE_NONE     = MODE_W'(0);
	localparam logic [MODE_W-1:0] MODE_ZIGZAG   = MODE_W'(1);
	localparam logic [MODE_W-1:0] MODE_CIRCULAR = MODE_W'(2);
	localparam logic [MODE_W-1:0] MODE_TRIANGLE = MODE_W'(3);
	localparam logic [MODE_W-1:0] MODE_FIGURE8  = MODE_W'(4);

	localparam logic [CFG_IDX_W-1:0] REG_MODE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_AMP  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_FREQ = CFG_IDX_W'(2);

	localparam logic [AMP_W-1:0]     AMP_RESET  = AMP_W'(33554);
	localparam logic [FREQ_W-1:0]    FREQ_RESET = FREQ_W'(131072);
	localparam logic [FREQ100_W-1:0] FREQ_SCALE = FREQ100_W'(100);

	localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [AMP_W-1:0]     amp;
		logic [FREQ100_W-1:0] freq100;
	} cfg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

endpackage

@@ hw/rtl/weld_weave_offset_generator.sv @@
// top level: weld weave offset generator, five stage pipeline
//
// channel   dir   handshake              payload
// in        in    in_valid / in_ready    pos_x..z, norm_x..z, tan_x..z, arc_len
// out       out   out_valid / out_ready  woven_x, woven_y, woven_z
// cfg       in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request per cycle while in_ready is high, out_valid rises once the request has passed s1 to s4 and reached s5
// s1 phase multiply and cross product, s2 sine rom read, s3 amplitude
// multiply, s4 vector moves, s5 saturating sum into the output register
// reset clears the stage valid bits and loads the configuration defaults, cfg_ready stays high
// a stage holds while the one after it is full and stalled, so in_ready
// falls only when all five stages hold requests and out_ready is low
`timescale 1ns / 1ps

module weld_weave_offset_generator #(
	parameter int PHASE_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [wwog_pkg::POS_W-1:0] pos_x,
	input  logic signed [wwog_pkg::POS_W-1:0] pos_y,
	input  logic signed [wwog_pkg::POS_W-1:0] pos_z,
	input  logic signed [wwog_pkg::VEC_W-1:0] norm_x,
	input  logic signed [wwog_pkg::VEC_W-1:0] norm_y,
	input  logic signed [wwog_pkg::VEC_W-1:0] norm_z,
	input  logic signed [wwog_pkg::VEC_W-1:0] tan_x,
	input  logic signed [wwog_pkg::VEC_W-1:0] tan_y,
	input  logic signed [wwog_pkg::VEC_W-1:0] tan_z,
	input  logic [wwog_pkg::ARC_W-1:0]        arc_len,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [wwog_pkg::POS_W-1:0] woven_x,
	output logic signed [wwog_pkg::POS_W-1:0] woven_y,
	output logic signed [wwog_pkg::POS_W-1:0] woven_z,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wwog_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wwog_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import wwog_pkg::*;

	cfg_t     cfg;
	pipe_en_t en;
	logic     v_s1;
	logic     v_s2;
	logic     v_s3;
	logic     v_s4;
	logic     v_s5;
	logic signed [OFF_W-1:0] off_s3;
	logic signed [OFF_W-1:0] voff_s3;

	assign en.s5 = !v_s5 || out_ready;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	assign in_ready  = en.s1;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	wwog_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	wwog_weave #(
		.PHASE_BITS(PHASE_BITS)
	) u_weave (
		.clk    (clk),
		.cfg    (cfg),
		.en     (en),
		.arc_len(arc_len),
		.off_s3 (off_s3),
		.voff_s3(voff_s3)
	);

	wwog_geom u_geom (
		.clk    (clk),
		.en     (en),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.pos_z  (pos_z),
		.norm_x (norm_x),
		.norm_y (norm_y),
		.norm_z (norm_z),
		.tan_x  (tan_x),
		.tan_y  (tan_y),
		.tan_z  (tan_z),
		.off_s3 (off_s3),
		.voff_s3(voff_s3),
		.woven_x(woven_x),
		.woven_y(woven_y),
		.woven_z(woven_z)
	);

	// requests in flight follow accepts and deliveries exactly
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |->
		($countones({v_s1, v_s2, v_s3, v_s4, v_s5}) ==
		 $countones($past({v_s1, v_s2, v_s3, v_s4, v_s5}))
		 + $past(in_valid && in_ready) - $past(out_valid && out_ready)))
		else $error("pipeline occupancy does not match handshakes");

	// a full, stalled pipeline takes no request
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !out_ready) |-> !in_ready)
		else $error("request accepted into a full pipeline");

	// stage s3 keeps its request while its successor stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en.s4) |=> v_s3)
		else $error("stalled stage dropped its request");

endmodule

@@ hw/rtl/wwog_cfg_regs.sv @@
// configuration registers with the frequency kept pre-scaled by 100
`timescale 1ns / 1ps

module wwog_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wwog_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wwog_pkg::CFG_DATA_W-1:0] cfg_data,
	output wwog_pkg::cfg_t                  cfg
);
	import wwog_pkg::*;

	logic [MODE_W-1:0]    mode_q;
	logic [AMP_W-1:0]     amp_q;
	logic [FREQ100_W-1:0] freq100_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NONE;
			amp_q     <= AMP_RESET;
			freq100_q <= FREQ100_W'(FREQ_RESET) * FREQ_SCALE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data[MODE_W-1:0];
				REG_AMP: amp_q <= cfg_data[AMP_W-1:0];
				REG_FREQ: freq100_q <= FREQ100_W'(cfg_data[FREQ_W-1:0]) * FREQ_SCALE;
				default: ;
			endcase
		end
	end

	assign cfg.mode    = mode_q;
	assign cfg.amp     = amp_q;
	assign cfg.freq100 = freq100_q;

endmodule

@@ hw/rtl/wwog_sine_rom.sv @@
// quarter wave sine rom, two registered read ports
`timescale 1ns / 1ps

module wwog_sine_rom #(
	parameter int PHASE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [PHASE_BITS-2:0]         addr_a,
	input  logic [PHASE_BITS-2:0]         addr_b,
	output logic [wwog_pkg::SIN_W-1:0]    data_a,
	output logic [wwog_pkg::SIN_W-1:0]    data_b
);
	import wwog_pkg::*;

	localparam int ADDR_W    = PHASE_BITS - 1;
	localparam int ROM_DEPTH = 2 ** ADDR_W;
	localparam int QLEN      = 2 ** (PHASE_BITS - 2);
	localparam int Q_FRAC    = 30;
	localparam int ROM_SHIFT = Q_FRAC - (PHASE_BITS - 2);
	localparam int RND_SHIFT = Q_FRAC - SIN_FRAC;

	localparam longint unsigned SIN_C1  = 64'd1686629713;
	localparam longint unsigned SIN_C3  = 64'd693598668;
	localparam longint unsigned SIN_C5  = 64'd85569306;
	localparam longint unsigned SIN_C7  = 64'd5026995;
	localparam longint unsigned SIN_C9  = 64'd172272;
	localparam longint unsigned SIN_ONE = 64'd1 << SIN_FRAC;
	localparam longint unsigned RND     = 64'd1 << (RND_SHIFT - 1);

	typedef logic [SIN_W-1:0] rom_t [ROM_DEPTH];

	// odd degree-9 polynomial, products truncated, rounded half up to q1.14
	function automatic rom_t build_rom();
		rom_t            t;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned y;
		for (int k = 0; k < ROM_DEPTH; k++) begin
			if (k <= QLEN) begin
				x  = 64'(k) << ROM_SHIFT;
				x2 = (x * x) >> Q_FRAC;
				y  = SIN_C9;
				y  = SIN_C7 - ((y * x2) >> Q_FRAC);
				y  = SIN_C5 - ((y * x2) >> Q_FRAC);
				y  = SIN_C3 - ((y * x2) >> Q_FRAC);
				y  = SIN_C1 - ((y * x2) >> Q_FRAC);
				y  = (y * x) >> Q_FRAC;
				y  = (y + RND) >> RND_SHIFT;
				if (y > SIN_ONE) begin
					y = SIN_ONE;
				end
				t[k] = SIN_W'(y);
			end else begin
				t[k] = '0;
			end
		end
		return t;
	endfunction

	localparam rom_t ROM = build_rom();

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_a <= ROM[addr_a];
			data_b <= ROM[addr_b];
		end
	end

endmodule

@@ hw/rtl/wwog_weave.sv @@
// weave phase, sine and triangle lookup, lateral and normal offsets (s1 to s3)
`timescale 1ns / 1ps

module wwog_weave #(
	parameter int PHASE_BITS = 12
) (
	input  logic                                clk,
	input  wwog_pkg::cfg_t                      cfg,
	input  wwog_pkg::pipe_en_t                  en,
	input  logic [wwog_pkg::ARC_W-1:0]          arc_len,
	output logic signed [wwog_pkg::OFF_W-1:0]   off_s3,
	output logic signed [wwog_pkg::OFF_W-1:0]   voff_s3
);
	import wwog_pkg::*;

	localparam int N       = 2 ** PHASE_BITS;
	localparam int QLEN    = N / 4;
	localparam int ADDR_W  = PHASE_BITS - 1;
	localparam int TRI_W   = PHASE_BITS + 3;
	localparam int MAG_W   = PHASE_BITS + 1;
	localparam int MUL_W   = (MAG_W > SIN_W) ? MAG_W : SIN_W;
	localparam int LPROD_W = AMP_W + MUL_W;
	localparam int VPROD_W = AMP_W + SIN_W;
	localparam int PROD_W  = ARC_W + FREQ100_W;

	// stage 1: phase product
	logic [PROD_W-1:0]     phase_prod;
	logic [PHASE_BITS-1:0] ph_s1;

	assign phase_prod = PROD_W'(arc_len) * PROD_W'(cfg.freq100);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			ph_s1 <= phase_prod[PHASE_FRAC-1 -: PHASE_BITS];
		end
	end

	// stage 2: table addresses and triangle wave
	function automatic logic [PHASE_BITS-1:0] fold(input logic [PHASE_BITS-1:0] idx);
		logic [ADDR_W-1:0] r;
		logic [ADDR_W-1:0] k;
		r = {1'b0, idx[PHASE_BITS-3:0]};
		k = idx[PHASE_BITS-2] ? ADDR_W'(QLEN) - r : r;
		return {idx[PHASE_BITS-1], k};
	endfunction

	logic [PHASE_BITS-1:0] idx_a;
	logic [PHASE_BITS-1:0] idx_b;
	logic [PHASE_BITS-1:0] fold_a;
	logic [PHASE_BITS-1:0] fold_b;
	logic [PHASE_BITS+1:0] ph_x4;
	logic signed [TRI_W-1:0] tri_w;
	logic signed [TRI_W-1:0] tri_abs;
	logic [SIN_W-1:0]      sin_a_s2;
	logic [SIN_W-1:0]      sin_b_s2;
	logic                  nega_s2;
	logic                  negb_s2;
	logic                  wneg_s2;
	logic [MAG_W-1:0]      wmag_s2;

	always_comb begin
		idx_a = ph_s1;
		idx_b = ph_s1;
		case (cfg.mode)
			MODE_CIRCULAR: idx_b = ph_s1 + PHASE_BITS'(QLEN);
			MODE_FIGURE8: idx_a = {ph_s1[PHASE_BITS-2:0], 1'b0};
			default: ;
		endcase
	end

	assign fold_a = fold(idx_a);
	assign fold_b = fold(idx_b);

	assign ph_x4   = {ph_s1, 2'b00};
	assign tri_w   = ph_s1[PHASE_BITS-1] ? TRI_W'(3 * N) - TRI_W'(ph_x4)
	                                     : TRI_W'(ph_x4) - TRI_W'(N);
	assign tri_abs = tri_w[TRI_W-1] ? -tri_w : tri_w;

	wwog_sine_rom #(
		.PHASE_BITS(PHASE_BITS)
	) u_rom (
		.clk   (clk),
		.rd_en (en.s2),
		.addr_a(fold_a[ADDR_W-1:0]),
		.addr_b(fold_b[ADDR_W-1:0]),
		.data_a(sin_a_s2),
		.data_b(sin_b_s2)
	);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			nega_s2 <= fold_a[PHASE_BITS-1];
			negb_s2 <= fold_b[PHASE_BITS-1];
			wneg_s2 <= tri_w[TRI_W-1];
			wmag_s2 <= tri_abs[MAG_W-1:0];
		end
	end

	// stage 3: scale by amplitude, truncate toward zero
	logic                  lat_on;
	logic                  vert_on;
	logic                  lat_sine;
	logic                  lat_neg;
	logic [MUL_W-1:0]      lat_mult;
	logic [LPROD_W-1:0]    lat_prod;
	logic [VPROD_W-1:0]    vert_prod;
	logic [AMP_W-1:0]      lat_mag;
	logic [AMP_W-1:0]      vert_mag;
	logic signed [OFF_W-1:0] off_next;
	logic signed [OFF_W-1:0] voff_next;

	always_comb begin
		lat_on   = 1'b0;
		vert_on  = 1'b0;
		lat_sine = 1'b0;
		case (cfg.mode)
			MODE_ZIGZAG, MODE_TRIANGLE: lat_on = 1'b1;
			MODE_CIRCULAR, MODE_FIGURE8: begin
				lat_on   = 1'b1;
				vert_on  = 1'b1;
				lat_sine = 1'b1;
			end
			MODE_NONE: ;
			default: ;
		endcase
	end

	assign lat_mult  = lat_sine ? MUL_W'(sin_a_s2) : MUL_W'(wmag_s2);
	assign lat_neg   = lat_sine ? nega_s2 : wneg_s2;
	assign lat_prod  = LPROD_W'(cfg.amp) * LPROD_W'(lat_mult);
	assign vert_prod = VPROD_W'(cfg.amp) * VPROD_W'(sin_b_s2);
	assign lat_mag   = lat_sine ? AMP_W'(lat_prod >> SIN_FRAC) : AMP_W'(lat_prod >> PHASE_BITS);
	assign vert_mag  = AMP_W'(vert_prod >> (SIN_FRAC + 1));

	always_comb begin
		off_next  = '0;
		voff_next = '0;
		if (lat_on) begin
			off_next = lat_neg ? -$signed({1'b0, lat_mag}) : $signed({1'b0, lat_mag});
		end
		if (vert_on) begin
			voff_next = negb_s2 ? -$signed({1'b0, vert_mag}) : $signed({1'b0, vert_mag});
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			off_s3  <= off_next;
			voff_s3 <= voff_next;
		end
	end

endmodule

@@ hw/rtl/wwog_geom.sv @@
// lateral cross product, vector moves and saturating sum (s1 to s5)
`timescale 1ns / 1ps

module wwog_geom (
	input  logic                               clk,
	input  wwog_pkg::pipe_en_t                 en,
	input  logic signed [wwog_pkg::POS_W-1:0]  pos_x,
	input  logic signed [wwog_pkg::POS_W-1:0]  pos_y,
	input  logic signed [wwog_pkg::POS_W-1:0]  pos_z,
	input  logic signed [wwog_pkg::VEC_W-1:0]  norm_x,
	input  logic signed [wwog_pkg::VEC_W-1:0]  norm_y,
	input  logic signed [wwog_pkg::VEC_W-1:0]  norm_z,
	input  logic signed [wwog_pkg::VEC_W-1:0]  tan_x,
	input  logic signed [wwog_pkg::VEC_W-1:0]  tan_y,
	input  logic signed [wwog_pkg::VEC_W-1:0]  tan_z,
	input  logic signed [wwog_pkg::OFF_W-1:0]  off_s3,
	input  logic signed [wwog_pkg::OFF_W-1:0]  voff_s3,
	output logic signed [wwog_pkg::POS_W-1:0]  woven_x,
	output logic signed [wwog_pkg::POS_W-1:0]  woven_y,
	output logic signed [wwog_pkg::POS_W-1:0]  woven_z
);
	import wwog_pkg::*;

	localparam int PRD_W     = 2 * VEC_W;
	localparam int LAT_ABS_W = LAT_W - 1;
	localparam int LP_W      = LAT_ABS_W + AMP_W;
	localparam int NP_W      = VEC_W + AMP_W;

	// stage 1: tangent cross normal
	logic signed [PRD_W-1:0] m_yz;
	logic signed [PRD_W-1:0] m_zy;
	logic signed [PRD_W-1:0] m_zx;
	logic signed [PRD_W-1:0] m_xz;
	logic signed [PRD_W-1:0] m_xy;
	logic signed [PRD_W-1:0] m_yx;
	logic signed [LAT_W-1:0] lat_next [3];

	assign m_yz = tan_y * norm_z;
	assign m_zy = tan_z * norm_y;
	assign m_zx = tan_z * norm_x;
	assign m_xz = tan_x * norm_z;
	assign m_xy = tan_x * norm_y;
	assign m_yx = tan_y * norm_x;

	assign lat_next[0] = {m_yz[PRD_W-1], m_yz} - {m_zy[PRD_W-1], m_zy};
	assign lat_next[1] = {m_zx[PRD_W-1], m_zx} - {m_xz[PRD_W-1], m_xz};
	assign lat_next[2] = {m_xy[PRD_W-1], m_xy} - {m_yx[PRD_W-1], m_yx};

	logic signed [POS_W-1:0] pos_s1 [3];
	logic signed [POS_W-1:0] pos_s2 [3];
	logic signed [POS_W-1:0] pos_s3 [3];
	logic signed [POS_W-1:0] pos_s4 [3];
	logic signed [VEC_W-1:0] nrm_s1 [3];
	logic signed [VEC_W-1:0] nrm_s2 [3];
	logic signed [VEC_W-1:0] nrm_s3 [3];
	logic signed [LAT_W-1:0] lat_s1 [3];
	logic signed [LAT_W-1:0] lat_s2 [3];
	logic signed [LAT_W-1:0] lat_s3 [3];

	always_ff @(posedge clk) begin
		if (en.s1) begin
			pos_s1 <= '{pos_x, pos_y, pos_z};
			nrm_s1 <= '{norm_x, norm_y, norm_z};
			lat_s1 <= lat_next;
		end
		if (en.s2) begin
			pos_s2 <= pos_s1;
			nrm_s2 <= nrm_s1;
			lat_s2 <= lat_s1;
		end
		if (en.s3) begin
			pos_s3 <= pos_s2;
			nrm_s3 <= nrm_s2;
			lat_s3 <= lat_s2;
		end
	end

	// stage 4: lateral and normal moves, truncated toward zero
	logic [AMP_W-1:0]       off_abs;
	logic [AMP_W-1:0]       voff_abs;
	logic [LAT_ABS_W-1:0]   lat_abs  [3];
	logic [LP_W-1:0]        lat_prod [3];
	logic [VEC_W-1:0]       nrm_abs  [3];
	logic [NP_W-1:0]        nrm_prod [3];
	logic signed [LM_W-1:0] lm_next  [3];
	logic signed [NM_W-1:0] nm_next  [3];
	logic signed [LM_W-1:0] lm_s4    [3];
	logic signed [NM_W-1:0] nm_s4    [3];

	assign off_abs  = off_s3[OFF_W-1] ? AMP_W'(-off_s3) : AMP_W'(off_s3);
	assign voff_abs = voff_s3[OFF_W-1] ? AMP_W'(-voff_s3) : AMP_W'(voff_s3);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lat_abs[i]  = lat_s3[i][LAT_W-1] ? LAT_ABS_W'(-lat_s3[i]) : LAT_ABS_W'(lat_s3[i]);
			lat_prod[i] = LP_W'(lat_abs[i]) * LP_W'(off_abs);
			lm_next[i]  = (lat_s3[i][LAT_W-1] ^ off_s3[OFF_W-1])
			            ? -LM_W'(lat_prod[i][LP_W-1:LAT_SHIFT])
			            : LM_W'(lat_prod[i][LP_W-1:LAT_SHIFT]);
			nrm_abs[i]  = nrm_s3[i][VEC_W-1] ? VEC_W'(-nrm_s3[i]) : VEC_W'(nrm_s3[i]);
			nrm_prod[i] = NP_W'(nrm_abs[i]) * NP_W'(voff_abs);
			nm_next[i]  = (nrm_s3[i][VEC_W-1] ^ voff_s3[OFF_W-1])
			            ? -NM_W'(nrm_prod[i][NP_W-1:SIN_FRAC])
			            : NM_W'(nrm_prod[i][NP_W-1:SIN_FRAC]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			pos_s4 <= pos_s3;
			lm_s4  <= lm_next;
			nm_s4  <= nm_next;
		end
	end

	// stage 5: sum and saturate
	logic signed [SUM_W-1:0] sum     [3];
	logic signed [POS_W-1:0] sat_sum [3];
	logic signed [POS_W-1:0] wov_s5  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = SUM_W'(pos_s4[i]) + SUM_W'(lm_s4[i]) + SUM_W'(nm_s4[i]);
			if ((&sum[i][SUM_W-1:POS_W-1]) || !(|sum[i][SUM_W-1:POS_W-1])) begin
				sat_sum[i] = sum[i][POS_W-1:0];
			end else begin
				sat_sum[i] = sum[i][SUM_W-1] ? POS_MIN : POS_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			wov_s5 <= sat_sum;
		end
	end

	assign woven_x = wov_s5[0];
	assign woven_y = wov_s5[1];
	assign woven_z = wov_s5[2];

endmodule

@@ tb/sv/weld_weave_offset_generator_tb.sv @@
// testbench for the weld weave offset generator: directed and random path points
`timescale 1ns / 1ps

module weld_weave_offset_generator_tb;
	import wwog_pkg::*;

	localparam int PHASE_BITS = 12;
	localparam int PHASE_N    = 1 << PHASE_BITS;
	localparam int LIMIT_NS   = 2_000_000;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

	// quarter wave polynomial coefficients, Q2.30
	localparam longint unsigned POLY_K1 = 64'd1686629713;
	localparam longint unsigned POLY_K3 = 64'd693598668;
	localparam longint unsigned POLY_K5 = 64'd85569306;
	localparam longint unsigned POLY_K7 = 64'd5026995;
	localparam longint unsigned POLY_K9 = 64'd172272;

	typedef struct packed {
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic [POS_W-1:0] pz;
		logic [VEC_W-1:0] nx;
		logic [VEC_W-1:0] ny;
		logic [VEC_W-1:0] nz;
		logic [VEC_W-1:0] tx;
		logic [VEC_W-1:0] ty;
		logic [VEC_W-1:0] tz;
		logic [ARC_W-1:0] arc;
	} point_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] z;
	} woven_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic signed [POS_W-1:0]      pos_x;
	logic signed [POS_W-1:0]      pos_y;
	logic signed [POS_W-1:0]      pos_z;
	logic signed [VEC_W-1:0]      norm_x;
	logic signed [VEC_W-1:0]      norm_y;
	logic signed [VEC_W-1:0]      norm_z;
	logic signed [VEC_W-1:0]      tan_x;
	logic signed [VEC_W-1:0]      tan_y;
	logic signed [VEC_W-1:0]      tan_z;
	logic [ARC_W-1:0]             arc_len;
	logic                         out_valid;
	logic                         out_ready;
	logic signed [POS_W-1:0]      woven_x;
	logic signed [POS_W-1:0]      woven_y;
	logic signed [POS_W-1:0]      woven_z;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index;
	logic [CFG_DATA_W-1:0]        cfg_data;

	logic [MODE_W-1:0] cfg_mode = MODE_NONE;
	logic [AMP_W-1:0]  cfg_amp  = AMP_RESET;
	logic [FREQ_W-1:0] cfg_freq = FREQ_RESET;

	woven_t      woven_expected_q[$];
	int unsigned mismatch_count;
	bit          tx_idle;
	bit          rx_idle;
	int unsigned rx_hold_cycles;

	weld_weave_offset_generator #(
		.PHASE_BITS(PHASE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.norm_x(norm_x),
		.norm_y(norm_y),
		.norm_z(norm_z),
		.tan_x(tan_x),
		.tan_y(tan_y),
		.tan_z(tan_z),
		.arc_len(arc_len),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.woven_x(woven_x),
		.woven_y(woven_y),
		.woven_z(woven_z),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// a*b scaled down by 2^sh, truncated toward zero
	function automatic longint scale_trunc(input longint a, input longint b,
			input int unsigned sh);
		longint unsigned ua, ub, pr;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		pr = (ua * ub) >> sh;
		return ((a < 0) != (b < 0)) ? -longint'(pr) : longint'(pr);
	endfunction

	// sin(pi/2 * x), x in Q2.30, result Q1.14
	function automatic int quarter_wave(input longint unsigned x);
		longint unsigned x2, y;
		x2 = (x * x) >> 30;
		y  = POLY_K9;
		y  = POLY_K7 - ((y * x2) >> 30);
		y  = POLY_K5 - ((y * x2) >> 30);
		y  = POLY_K3 - ((y * x2) >> 30);
		y  = POLY_K1 - ((y * x2) >> 30);
		y  = (y * x) >> 30;
		y  = (y + 64'd32768) >> 16;
		if (y > 64'd16384) begin
			y = 64'd16384;
		end
		return int'(y);
	endfunction

	function automatic int sine_q14(input int unsigned p);
		int unsigned qlen, q, r, k;
		int s;
		qlen = PHASE_N / 4;
		p    = p & (PHASE_N - 1);
		q    = p / qlen;
		r    = p % qlen;
		k    = q[0] ? (qlen - r) : r;
		s    = quarter_wave(64'(k) << (30 - (PHASE_BITS - 2)));
		return (q >= 2) ? -s : s;
	endfunction

	function automatic woven_t weave_point(input point_t pt);
		longint pos[3], nrm[3], tng[3], lat[3], moved[3];
		longint unsigned prod;
		longint amp, w, lat_off, norm_off;
		int unsigned ph;
		logic [POS_W-1:0] coord[3];
		woven_t res;
		pos[0] = longint'($signed(pt.px));
		pos[1] = longint'($signed(pt.py));
		pos[2] = longint'($signed(pt.pz));
		nrm[0] = longint'($signed(pt.nx));
		nrm[1] = longint'($signed(pt.ny));
		nrm[2] = longint'($signed(pt.nz));
		tng[0] = longint'($signed(pt.tx));
		tng[1] = longint'($signed(pt.ty));
		tng[2] = longint'($signed(pt.tz));
		lat[0] = tng[1] * nrm[2] - tng[2] * nrm[1];
		lat[1] = tng[2] * nrm[0] - tng[0] * nrm[2];
		lat[2] = tng[0] * nrm[1] - tng[1] * nrm[0];
		prod = 64'(pt.arc) * 64'(FREQ_SCALE) * 64'(cfg_freq);
		ph = 32'((prod >> (PHASE_FRAC - PHASE_BITS)) & 64'(PHASE_N - 1));
		amp = longint'(cfg_amp);
		lat_off = 0;
		norm_off = 0;
		case (cfg_mode)
			MODE_ZIGZAG, MODE_TRIANGLE: begin
				w = (ph < PHASE_N / 2) ? (4 * longint'(ph) - PHASE_N)
					: (3 * PHASE_N - 4 * longint'(ph));
				lat_off = scale_trunc(amp, w, PHASE_BITS);
			end
			MODE_CIRCULAR: begin
				lat_off  = scale_trunc(amp, sine_q14(ph), SIN_FRAC);
				norm_off = scale_trunc(amp, sine_q14(ph + PHASE_N / 4), SIN_FRAC + 1);
			end
			MODE_FIGURE8: begin
				lat_off  = scale_trunc(amp, sine_q14(ph << 1), SIN_FRAC);
				norm_off = scale_trunc(amp, sine_q14(ph), SIN_FRAC + 1);
			end
			default: begin
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			moved[i] = pos[i] + scale_trunc(lat[i], lat_off, LAT_SHIFT)
				+ scale_trunc(nrm[i], norm_off, SIN_FRAC);
			if (moved[i] > longint'($signed(POS_MAX))) begin
				moved[i] = longint'($signed(POS_MAX));
			end else if (moved[i] < longint'($signed(POS_MIN))) begin
				moved[i] = longint'($signed(POS_MIN));
			end
			coord[i] = POS_W'(moved[i]);
		end
		res.x = coord[0];
		res.y = coord[1];
		res.z = coord[2];
		return res;
	endfunction

	function automatic point_t make_point(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
			input logic [POS_W-1:0] pz, input logic [VEC_W-1:0] nx, input logic [VEC_W-1:0] ny,
			input logic [VEC_W-1:0] nz, input logic [VEC_W-1:0] tx, input logic [VEC_W-1:0] ty,
			input logic [VEC_W-1:0] tz, input logic [ARC_W-1:0] arc);
		point_t pt;
		pt.px  = px;
		pt.py  = py;
		pt.pz  = pz;
		pt.nx  = nx;
		pt.ny  = ny;
		pt.nz  = nz;
		pt.tx  = tx;
		pt.ty  = ty;
		pt.tz  = tz;
		pt.arc = arc;
		return pt;
	endfunction

	function automatic logic [POS_W-1:0] random_coord();
		case ($urandom_range(0, 3))
			0: return POS_MAX - POS_W'($urandom_range(0, 1 << 25));
			1: return POS_MIN + POS_W'($urandom_range(0, 1 << 25));
			2: return POS_W'($urandom_range(0, 1 << 29) - (1 << 28));
			default: return POS_W'($urandom);
		endcase
	endfunction

	function automatic logic [VEC_W-1:0] random_component();
		case ($urandom_range(0, 3))
			0: return VEC_W'($urandom);
			1: begin
				case ($urandom_range(0, 4))
					0: return VEC_W'(16384);
					1: return VEC_W'(-16384);
					2: return VEC_W'(0);
					3: return VEC_W'(32767);
					default: return VEC_W'(-32768);
				endcase
			end
			default: return VEC_W'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	function automatic point_t random_point();
		return make_point(random_coord(), random_coord(), random_coord(),
			random_component(), random_component(), random_component(),
			random_component(), random_component(), random_component(),
			ARC_W'($urandom));
	endfunction

	task automatic send_point(input point_t pt);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pos_x    <= pt.px;
		pos_y    <= pt.py;
		pos_z    <= pt.pz;
		norm_x   <= pt.nx;
		norm_y   <= pt.ny;
		norm_z   <= pt.nz;
		tan_x    <= pt.tx;
		tan_y    <= pt.ty;
		tan_z    <= pt.tz;
		arc_len  <= pt.arc;
		do @(posedge clk); while (in_ready !== 1'b1);
		woven_expected_q = {woven_expected_q, weave_point(pt)};
	endtask

	// stop offering points and let the pipeline empty
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (woven_expected_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		drain_pipeline();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_MODE: cfg_mode = data[MODE_W-1:0];
			REG_AMP:  cfg_amp  = data[AMP_W-1:0];
			REG_FREQ: cfg_freq = data[FREQ_W-1:0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_coord(input string name, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t %s expected %0d actual %0d", $time, name, $signed(want), $signed(got));
		end
	endtask

	initial begin : result_monitor
		int unsigned pause;
		woven_t want;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			pause = rx_idle ? $urandom_range(0, 9) : 0;
			if (rx_hold_cycles != 0) begin
				pause = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (pause != 0) begin
				out_ready <= 1'b0;
				repeat (pause) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (woven_expected_q.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected result expected none actual %0d %0d %0d",
					$time, woven_x, woven_y, woven_z);
			end else begin
				want = woven_expected_q.pop_front();
				check_coord("woven_x", want.x, woven_x);
				check_coord("woven_y", want.y, woven_y);
				check_coord("woven_z", want.z, woven_z);
			end
		end
	end

	// reset registers: mode none passes points through
	task automatic test_pass_through();
		send_point(make_point(POS_MAX, POS_MIN, 0, 16384, -16384, 0, -32768, 32767, 16384,
			32'hFFFF_FFFF));
		send_point(make_point(POS_MIN, POS_MAX, -1, -32768, 32767, -16384, 0, 0, 0, 0));
		send_point(random_point());
	endtask

	// zigzag with reset amplitude and frequency
	task automatic test_reset_weave();
		write_register(REG_MODE, CFG_DATA_W'(MODE_ZIGZAG));
		send_point(make_point(0, 0, 0, 0, 0, 16384, 16384, 0, 0, 0));
		send_point(make_point(random_coord(), 0, 0, 0, 0, 16384, 16384, 0, 0, ARC_W'($urandom)));
	endtask

	task automatic test_mode_extremes();
		write_register(REG_AMP, {AMP_W{1'b1}});
		write_register(REG_FREQ, CFG_DATA_W'({FREQ_W{1'b1}}));
		write_register(REG_MODE, CFG_DATA_W'(MODE_CIRCULAR));
		send_point(make_point(POS_MAX, POS_MAX, POS_MAX, 16384, 16384, 16384, -16384, 16384, 0,
			ARC_W'($urandom)));
		send_point(make_point(POS_MIN, POS_MIN, POS_MIN, -16384, -16384, -16384, 16384, -16384, 0,
			ARC_W'($urandom)));
		write_register(REG_MODE, CFG_DATA_W'(MODE_FIGURE8));
		send_point(make_point(POS_MIN, POS_MAX, 0, -32768, -32768, -32768, -32768, 32767, -32768,
			ARC_W'($urandom)));
		send_point(random_point());
		write_register(REG_AMP, CFG_DATA_W'(25'h100_0000));
		write_register(REG_FREQ, CFG_DATA_W'(1));
		write_register(REG_MODE, CFG_DATA_W'(MODE_TRIANGLE));
		send_point(make_point(0, 0, 0, 0, 16384, 0, 0, 0, 16384, 32'hFFFF_FFFF));
		send_point(make_point(0, 0, 0, 0, 16384, 0, 0, 0, 16384, 32'h1234_5678));
		write_register(REG_AMP, '0);
		write_register(REG_MODE, CFG_DATA_W'(MODE_CIRCULAR));
		send_point(random_point());
		write_register(REG_AMP, CFG_DATA_W'(25'h100_0000));
		write_register(REG_FREQ, '0);
		send_point(make_point(0, 0, 0, 16384, -16384, 16384, 16384, 16384, 0, ARC_W'($urandom)));
	endtask

	// mode codes above figure eight and the spare register index
	task automatic test_unused_codes();
		write_register(REG_FREQ, CFG_DATA_W'($urandom));
		write_register(REG_AMP, CFG_DATA_W'($urandom));
		for (int m = int'(MODE_FIGURE8) + 1; m < (1 << MODE_W); m++) begin
			write_register(REG_MODE, CFG_DATA_W'(m));
			send_point(random_point());
		end
		write_register(REG_MODE, CFG_DATA_W'(MODE_CIRCULAR));
		write_register(REG_SPARE, CFG_DATA_W'($urandom));
		send_point(random_point());
	endtask

	// receiver stalls long while points keep coming
	task automatic test_back_pressure();
		write_register(REG_MODE, CFG_DATA_W'(MODE_FIGURE8));
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold_cycles = 80;
		repeat (40) send_point(random_point());
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_random_weave();
		logic [CFG_DATA_W-1:0] word;
		for (int ph = 0; ph < 8; ph++) begin
			word = CFG_DATA_W'($urandom);
			if ($urandom_range(0, 9) < 8) begin
				word[MODE_W-1:0] = MODE_W'($urandom_range(int'(MODE_ZIGZAG), int'(MODE_FIGURE8)));
			end
			write_register(REG_MODE, word);
			case ($urandom_range(0, 4))
				0: word = '0;
				1: word = CFG_DATA_W'(25'h100_0000);
				2: word = '1;
				3: word = CFG_DATA_W'($urandom);
				default: word = CFG_DATA_W'($urandom_range(0, 1 << 20));
			endcase
			write_register(REG_AMP, word);
			case ($urandom_range(0, 3))
				0: word = '0;
				1: word = '1;
				2: word = CFG_DATA_W'($urandom_range(0, 1 << 20));
				default: word = CFG_DATA_W'($urandom);
			endcase
			write_register(REG_FREQ, word);
			tx_idle = (ph % 3) != 1;
			rx_idle = (ph % 3) == 0;
			repeat (112) send_point(random_point());
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	initial begin : test_sequence
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		pos_x          = '0;
		pos_y          = '0;
		pos_z          = '0;
		norm_x         = '0;
		norm_y         = '0;
		norm_z         = '0;
		tan_x          = '0;
		tan_y          = '0;
		tan_z          = '0;
		arc_len        = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		tx_idle        = 1'b1;
		rx_idle        = 1'b1;
		rx_hold_cycles = 0;
		mismatch_count = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_pass_through();
		test_reset_weave();
		test_mode_extremes();
		test_unused_codes();
		test_back_pressure();
		test_random_weave();
		drain_pipeline();
		if (mismatch_count == 0) begin
			$display("weld_weave_offset_generator verification clean");
		end else begin
			$display("weld_weave_offset_generator verification failed");
		end
		$finish;
	end

	initial begin : run_limit
		#(LIMIT_NS);
		$display("weld_weave_offset_generator verification failed");
		$finish;
	end

endmodule
